// ===== rtl/core/frt_pkg.sv =====
package frt_pkg;

  localparam logic [2:0] ST_WAIT     = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_PRUNE    = 3'd4;

  localparam logic CMD_FRAG  = 1'b0;
  localparam logic CMD_PRUNE = 1'b1;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_MAXLEN  = 1'b1;

  localparam logic [31:0] TIMEOUT_RST = 32'd30000;
  localparam logic [12:0] MAXLEN_RST  = 13'd4096;

  // One queued transaction between the front and back parts
  typedef struct packed {
    logic        command;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [7:0]  frag_index;
    logic [7:0]  total_frags;
    logic [8:0]  size;
    logic [31:0] now_ms;
  } frt_item_t;

endpackage

// ===== rtl/core/frt_front.sv =====
module frt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  frt_pkg::frt_item_t  in_item,
  output logic                q_full,
  output logic                q_valid,
  output frt_pkg::frt_item_t  q_item,
  input  logic                q_pop
);
  import frt_pkg::*;

  // Two-entry queue that parts the front from the back
  frt_item_t  ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;

  assign q_full  = cnt_r[1];
  assign q_valid = cnt_r != 2'd0;
  assign q_item  = ent_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, in_valid} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (in_valid) ent_r[wr_r] <= in_item;
  end

endmodule

// ===== rtl/core/frt_back.sv =====
module frt_back #(
  parameter int SLOT_COUNT    = 8,
  parameter int MAX_FRAGMENTS = 16,
  parameter int CHUNK_BYTES   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  frt_pkg::frt_item_t q_item,
  output logic               q_pop,
  input  logic [31:0]        timeout_ms,
  input  logic [12:0]        max_total_length,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [2:0]         out_slot,
  output logic               out_is_new_fragment,
  output logic               out_evicted,
  output logic [12:0]        out_total_length,
  output logic [7:0]         out_expired_mask
);
  import frt_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int CW = $clog2(MAX_FRAGMENTS + 1);
  localparam int LW = $clog2(MAX_FRAGMENTS * CHUNK_BYTES + 1);
  localparam int XW = LW > 13 ? LW : 13;
  localparam int MD = 1 << (SW + FW);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_UPD, S_SUM, S_OUT} state_t;

  state_t state_r;
  frt_item_t it_r;

  logic [SLOT_COUNT-1:0]    act_r;
  logic [63:0]              idh_r [SLOT_COUNT];
  logic [63:0]              idl_r [SLOT_COUNT];
  logic [31:0]              start_r [SLOT_COUNT];
  logic [7:0]               exp_r [SLOT_COUNT];
  logic [CW-1:0]            rcnt_r [SLOT_COUNT];
  logic [MAX_FRAGMENTS-1:0] map_r [SLOT_COUNT];

  // Fragment size table, one row per slot; entries count only where the map bit is set
  logic [8:0]        size_mem [MD];
  logic [8:0]        mem_rd_r;
  logic              mem_we;
  logic [SW+FW-1:0]  mem_wa, mem_ra;
  logic [8:0]        mem_wd;

  logic [SW-1:0]   s_r;
  logic            ev_r, new_r;
  logic [FW:0]     sum_i_r;
  logic [XW-1:0]   sum_r, sum_now;
  logic            add_r;
  logic [2:0]      st_r;
  logic [12:0]     len_r;
  logic [7:0]      mask_r;

  // Combinational lookup, free search, oldest search and prune selection
  logic                  hit;
  logic [SW-1:0]         hit_s, free_s, old_s, claim_s;
  logic                  has_free;
  logic [31:0]           best_age, age;
  logic [SLOT_COUNT-1:0] prune_hit;
  logic [7:0]            prune_mask;
  always_comb begin
    hit = 1'b0; hit_s = '0; has_free = 1'b0; free_s = '0;
    old_s = '0; best_age = it_r.now_ms - start_r[0];
    prune_hit = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (act_r[i] && idh_r[i] == it_r.id_high && idl_r[i] == it_r.id_low) begin
        hit = 1'b1; hit_s = SW'(i);
      end
      if (!act_r[i]) begin
        has_free = 1'b1; free_s = SW'(i);
      end
      if (act_r[i] && (it_r.now_ms - start_r[i]) > timeout_ms) prune_hit[i] = 1'b1;
    end
    for (int i = 1; i < SLOT_COUNT; i++) begin
      age = it_r.now_ms - start_r[i];
      if (age > best_age) begin
        best_age = age; old_s = SW'(i);
      end
    end
    claim_s    = has_free ? free_s : old_s;
    prune_mask = 8'(prune_hit);
  end

  logic in_range;
  assign in_range = it_r.frag_index < 8'(MAX_FRAGMENTS);
  logic [FW-1:0] fi;
  assign fi = it_r.frag_index[FW-1:0];

  assign q_pop = (state_r == S_IDLE) && q_valid;

  // Size table access: write a new fragment, read one entry a cycle while summing
  assign mem_we  = (state_r == S_UPD) && in_range && !map_r[s_r][fi];
  assign mem_wa  = {s_r, fi};
  assign mem_wd  = (int'(it_r.size) > CHUNK_BYTES) ? 9'(CHUNK_BYTES) : it_r.size;
  assign mem_ra  = {s_r, sum_i_r[FW-1:0]};
  assign sum_now = sum_r + (add_r ? XW'(mem_rd_r) : '0);

  always_ff @(posedge clk) begin
    if (mem_we) size_mem[mem_wa] <= mem_wd;
    mem_rd_r <= size_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      act_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == S_OUT);
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r    <= q_item;
            state_r <= S_LOOK;
          end
        end
        // Hit, or claim a slot; prune finishes here
        S_LOOK: begin
          new_r <= 1'b0;
          len_r <= '0;
          if (it_r.command == CMD_PRUNE) begin
            act_r   <= act_r & ~prune_hit;
            mask_r  <= prune_mask;
            ev_r    <= 1'b0;
            s_r     <= '0;
            st_r    <= ST_PRUNE;
            state_r <= S_OUT;
          end else begin
            mask_r <= '0;
            s_r    <= hit ? hit_s : claim_s;
            ev_r   <= !hit && !has_free;
            if (!hit) begin
              act_r[claim_s]   <= 1'b1;
              idh_r[claim_s]   <= it_r.id_high;
              idl_r[claim_s]   <= it_r.id_low;
              start_r[claim_s] <= it_r.now_ms;
              exp_r[claim_s]   <= '0;
              rcnt_r[claim_s]  <= '0;
              map_r[claim_s]   <= '0;
            end
            state_r <= S_UPD;
          end
        end
        // Record fragment or reject an out-of-range index, decide completion
        S_UPD: begin
          if (!in_range) begin
            st_r    <= ST_RANGE;
            state_r <= S_OUT;
          end else begin
            exp_r[s_r] <= it_r.total_frags;
            if (!map_r[s_r][fi]) begin
              map_r[s_r][fi] <= 1'b1;
              rcnt_r[s_r]    <= rcnt_r[s_r] + 1'b1;
              new_r          <= 1'b1;
            end
            if (8'(rcnt_r[s_r]) + {7'd0, !map_r[s_r][fi]} >= it_r.total_frags) begin
              sum_i_r <= '0;
              sum_r   <= '0;
              add_r   <= 1'b0;
              state_r <= S_SUM;
            end else begin
              st_r    <= ST_WAIT;
              state_r <= S_OUT;
            end
          end
        end
        // Sum sizes one entry a cycle; read data is registered and lands the cycle after its address
        S_SUM: begin
          sum_r <= sum_now;
          if (sum_i_r < (FW+1)'(MAX_FRAGMENTS) && 8'(sum_i_r) < exp_r[s_r]) begin
            add_r   <= map_r[s_r][sum_i_r[FW-1:0]];
            sum_i_r <= sum_i_r + 1'b1;
          end else begin
            add_r      <= 1'b0;
            act_r[s_r] <= 1'b0;
            if (sum_now > XW'(max_total_length)) st_r <= ST_TOO_LONG;
            else begin
              st_r  <= ST_DONE;
              len_r <= sum_now[12:0];
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_status          <= st_r;
          out_slot            <= 3'(s_r);
          out_is_new_fragment <= new_r;
          out_evicted         <= ev_r;
          out_total_length    <= len_r;
          out_expired_mask    <= mask_r;
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/fragment_reassembly_tracker.sv =====
// Fragment reassembly tracker. Each start pulse (taken while busy is low)
// queues one fragment or prune transaction; exactly one result follows,
// shown for a single cycle with out_valid, and cannot be stalled. A prune
// result passes the idle, lookup and output states; a fragment also passes
// the update state, and a completing one walks the summing state once per
// summed size entry (the announced total, capped at MAX_FRAGMENTS). A
// two-entry queue sits in front, so busy rises only while two transactions
// wait behind the one being processed. The user must write configuration
// only while no transaction is in flight; the block does not enforce it.
module fragment_reassembly_tracker #(
  parameter int SLOT_COUNT    = 8,
  parameter int MAX_FRAGMENTS = 16,
  parameter int CHUNK_BYTES   = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [63:0] in_packet_id_high,
  input  logic [63:0] in_packet_id_low,
  input  logic [7:0]  in_fragment_index,
  input  logic [7:0]  in_total_fragments,
  input  logic [8:0]  in_payload_size,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [2:0]  out_slot,
  output logic        out_is_new_fragment,
  output logic        out_evicted,
  output logic [12:0] out_total_length,
  output logic [7:0]  out_expired_mask,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import frt_pkg::*;

  frt_item_t in_item, q_item;
  logic q_full, q_valid, q_pop, acc;
  logic [31:0] timeout_r;
  logic [12:0] maxlen_r;

  assign in_item = '{in_command, in_packet_id_high, in_packet_id_low,
                     in_fragment_index, in_total_fragments, in_payload_size, in_now_ms};
  assign busy = q_full;
  assign acc  = start && !busy;
  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      maxlen_r  <= MAXLEN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TIMEOUT) timeout_r <= cfg_data;
      else maxlen_r <= cfg_data[12:0];
    end
  end

  frt_front u_front (
    .clk, .rst_n, .in_valid(acc), .in_item, .q_full, .q_valid, .q_item, .q_pop
  );

  frt_back #(
    .SLOT_COUNT(SLOT_COUNT), .MAX_FRAGMENTS(MAX_FRAGMENTS), .CHUNK_BYTES(CHUNK_BYTES)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .timeout_ms(timeout_r), .max_total_length(maxlen_r),
    .out_valid, .out_status, .out_slot, .out_is_new_fragment, .out_evicted,
    .out_total_length, .out_expired_mask
  );

  a_prune_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_PRUNE |-> out_expired_mask == 8'd0) else $error("mask");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_total_length == 13'd0) else $error("len");
  a_busy_acc: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !acc) else $error("acc");

endmodule

// ===== tb/tb_fragment_reassembly_tracker.sv =====
module tb_fragment_reassembly_tracker;
  import frt_pkg::*;

  localparam int NSLOT = 8;
  localparam int NFRAG = 16;
  localparam int CHUNK = 256;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic        is_new;
    logic        evicted;
    logic [12:0] total_length;
    logic [7:0]  expired_mask;
  } frt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic [63:0] in_packet_id_high = '0;
  logic [63:0] in_packet_id_low = '0;
  logic [7:0] in_fragment_index = '0;
  logic [7:0] in_total_fragments = '0;
  logic [8:0] in_payload_size = '0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [2:0] out_slot;
  logic out_is_new_fragment;
  logic out_evicted;
  logic [12:0] out_total_length;
  logic [7:0] out_expired_mask;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  fragment_reassembly_tracker dut (.*);

  always #4 clk = ~clk;

  // Predicted context table
  logic [31:0] tmo;
  logic [12:0] maxlen;
  logic        ctx_active [NSLOT];
  logic [63:0] ctx_hi [NSLOT];
  logic [63:0] ctx_lo [NSLOT];
  logic [31:0] ctx_start [NSLOT];
  logic [7:0]  ctx_expected [NSLOT];
  logic [4:0]  ctx_count [NSLOT];
  logic [15:0] ctx_map [NSLOT];
  logic [8:0]  ctx_sizes [NSLOT][NFRAG];

  frt_result_t pending_results[$];
  int fail_count = 0;
  int idle_cycles = 0;
  logic [31:0] clock_ms = 32'd100;

  function automatic frt_result_t predict_result(frt_item_t it);
    frt_result_t r;
    int s;
    bit hit;
    logic [31:0] best, age;
    logic [31:0] sum;
    r = '0;
    s = 0;
    hit = 0;
    if (it.command == CMD_PRUNE) begin
      for (int i = 0; i < NSLOT; i++)
        if (ctx_active[i] && (it.now_ms - ctx_start[i]) > tmo) begin
          ctx_active[i] = 1'b0;
          r.expired_mask[i] = 1'b1;
        end
      r.status = ST_PRUNE;
      return r;
    end
    for (int i = 0; i < NSLOT; i++)
      if (!hit && ctx_active[i] && ctx_hi[i] == it.id_high && ctx_lo[i] == it.id_low) begin
        s = i;
        hit = 1;
      end
    if (!hit) begin
      bit got;
      got = 0;
      for (int i = 0; i < NSLOT; i++)
        if (!got && !ctx_active[i]) begin
          s = i;
          got = 1;
        end
      if (!got) begin
        best = it.now_ms - ctx_start[0];
        s = 0;
        for (int i = 1; i < NSLOT; i++) begin
          age = it.now_ms - ctx_start[i];
          if (age > best) begin
            best = age;
            s = i;
          end
        end
        r.evicted = 1'b1;
      end
      ctx_active[s] = 1'b1;
      ctx_hi[s] = it.id_high;
      ctx_lo[s] = it.id_low;
      ctx_start[s] = it.now_ms;
      ctx_expected[s] = '0;
      ctx_count[s] = '0;
      ctx_map[s] = '0;
      for (int k = 0; k < NFRAG; k++) ctx_sizes[s][k] = '0;
    end
    r.slot = s[2:0];
    if (it.frag_index >= NFRAG) begin
      r.status = ST_RANGE;
      return r;
    end
    ctx_expected[s] = it.total_frags;
    if (!ctx_map[s][it.frag_index]) begin
      ctx_sizes[s][it.frag_index] = (it.size > CHUNK) ? 9'(CHUNK) : it.size;
      ctx_map[s][it.frag_index] = 1'b1;
      ctx_count[s] = ctx_count[s] + 5'd1;
      r.is_new = 1'b1;
    end
    if ({3'b0, ctx_count[s]} >= ctx_expected[s]) begin
      sum = '0;
      for (int k = 0; k < NFRAG; k++)
        if (k < ctx_expected[s]) sum += ctx_sizes[s][k];
      if (sum > maxlen) r.status = ST_TOO_LONG;
      else begin
        r.status = ST_DONE;
        r.total_length = sum[12:0];
      end
      ctx_active[s] = 1'b0;
    end else begin
      r.status = ST_WAIT;
    end
    return r;
  endfunction

  // Compare each result strobe with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      frt_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d", out_status);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          fail_count++;
        end
        if (out_slot !== e.slot) begin
          $error("slot: expected %0d actual %0d", e.slot, out_slot);
          fail_count++;
        end
        if (out_is_new_fragment !== e.is_new) begin
          $error("is_new_fragment: expected %0d actual %0d", e.is_new, out_is_new_fragment);
          fail_count++;
        end
        if (out_evicted !== e.evicted) begin
          $error("evicted: expected %0d actual %0d", e.evicted, out_evicted);
          fail_count++;
        end
        if (out_total_length !== e.total_length) begin
          $error("total_length: expected %0d actual %0d", e.total_length, out_total_length);
          fail_count++;
        end
        if (out_expired_mask !== e.expired_mask) begin
          $error("expired_mask: expected %0h actual %0h", e.expired_mask, out_expired_mask);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  int burst_left = 0;

  // Send one item; start stays high across back-to-back items
  task automatic send_item(frt_item_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    in_command <= it.command;
    in_packet_id_high <= it.id_high;
    in_packet_id_low <= it.id_low;
    in_fragment_index <= it.frag_index;
    in_total_fragments <= it.total_frags;
    in_payload_size <= it.size;
    in_now_ms <= it.now_ms;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_result(it));
    @(negedge clk);
    if (burst_left == 0) start <= 1'b0;
  endtask

  task automatic drain;
    if (burst_left != 0) start <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TIMEOUT) tmo = val;
    else maxlen = val[12:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic frt_item_t frag(logic [63:0] hi, logic [63:0] lo, logic [7:0] idx,
                                     logic [7:0] tot, logic [8:0] sz, logic [31:0] now);
    frt_item_t it;
    it.command = CMD_FRAG;
    it.id_high = hi;
    it.id_low = lo;
    it.frag_index = idx;
    it.total_frags = tot;
    it.size = sz;
    it.now_ms = now;
    return it;
  endfunction

  function automatic frt_item_t prune(logic [31:0] now);
    frt_item_t it;
    it = frag({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
              9'($urandom), now);
    it.command = CMD_PRUNE;
    return it;
  endfunction

  task automatic test_directed;
    send_item(frag('1, '1, 8'd0, 8'd0, 9'd511, 32'hFFFF_FFFF));    // zero total
    send_item(frag('0, '0, 8'd255, 8'd3, 9'd5, 32'd0));            // index out of range
    send_item(frag('0, '0, 8'd0, 8'd2, 9'd300, 32'd1));            // oversized size
    send_item(frag('0, '0, 8'd0, 8'd2, 9'd7, 32'd2));              // duplicate
    send_item(frag('0, '0, 8'd15, 8'd2, 9'd256, 32'd3));
    send_item(frag('0, '0, 8'd1, 8'd2, 9'd9, 32'd4));              // new context, waits
    send_item(frag(64'd5, 64'd5, 8'd0, 8'd200, 9'd1, 32'd5));      // never completes
    for (int i = 0; i < 9; i++)                                    // fill and evict
      send_item(frag(64'd100 + i, 64'd7, 8'd1, 8'd4, 9'd10, 32'd10));
    send_item(prune(32'd10));
    send_item(prune(32'd40000));
    for (int k = 0; k < 16; k++)                                   // exactly at the length limit
      send_item(frag(64'd9, 64'd9, k[7:0], 8'd16, 9'd256, 32'd50000));
  endtask

  task automatic test_config_sweep;
    write_reg(CFG_MAXLEN, 32'd0);
    write_reg(CFG_TIMEOUT, 32'd0);
    send_item(frag(64'd1, 64'd1, 8'd0, 8'd1, 9'd0, 32'd60000));
    send_item(frag(64'd2, 64'd1, 8'd0, 8'd1, 9'd1, 32'd60000));
    send_item(frag(64'd3, 64'd1, 8'd0, 8'd2, 9'd1, 32'd60000));
    send_item(prune(32'd60001));
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_MAXLEN, 32'h1FFF);
  endtask

  task automatic random_phase(int n);
    logic [63:0] pool_hi [6];
    logic [63:0] pool_lo [6];
    frt_item_t it;
    int p;
    for (int i = 0; i < 6; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end
    for (int j = 0; j < n; j++) begin
      clock_ms += $urandom_range(0, 3000);
      p = $urandom_range(0, 99);
      if (p < 6) it = prune(($urandom_range(0, 9) == 0) ? $urandom : clock_ms);
      else if (p < 12) begin
        it = frag({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                  9'($urandom), $urandom);
      end else begin
        int q;
        q = $urandom_range(0, 5);
        it = frag(pool_hi[q], pool_lo[q],
                  ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)),
                  ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)),
                  ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256)),
                  clock_ms);
        if ($urandom_range(0, 19) == 0) begin
          pool_hi[q] = {$urandom, $urandom};
          pool_lo[q] = {$urandom, $urandom};
        end
      end
      send_item(it);
      if (j == n / 2) drain();  // let every pending result arrive mid-phase
    end
  endtask

  task automatic test_random;
    write_reg(CFG_TIMEOUT, 32'd5000);
    write_reg(CFG_MAXLEN, 32'd600);
    random_phase(500);
    write_reg(CFG_TIMEOUT, 32'd30000);
    write_reg(CFG_MAXLEN, 32'd4096);
    random_phase(550);
    write_reg(CFG_TIMEOUT, $urandom);
    write_reg(CFG_MAXLEN, $urandom_range(0, 8191));
    random_phase(450);
  endtask

  initial begin
    tmo = TIMEOUT_RST;
    maxlen = MAXLEN_RST;
    for (int i = 0; i < NSLOT; i++) ctx_active[i] = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_sweep();
    test_random();
    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/frt_pkg.sv
rtl/core/frt_front.sv
rtl/core/frt_back.sv
rtl/core/fragment_reassembly_tracker.sv
tb/tb_fragment_reassembly_tracker.sv
